/* design/rpip_pkg.sv */
`timescale 1ns / 1ps
// types, sizes and codes shared by the point-in-polygon cells and the top level
// no dependencies

package rpip_pkg;

    localparam int MAX_VERTICES  = 64;
    localparam int MAX_OBSTACLES = 16;
    localparam int COORD_BITS    = 12;

    localparam int VCOUNT_W = $clog2(MAX_VERTICES + 1);
    localparam int OCOUNT_W = $clog2(MAX_OBSTACLES + 1);
    localparam int SLOT_W   = 6;
    localparam int HALF_W   = COORD_BITS - 1;

    typedef logic [COORD_BITS-1:0] t_coord;
    typedef logic [HALF_W-1:0]     t_half;

    typedef enum logic [1:0] {
        OP_LOAD_VERTEX   = 2'd0,
        OP_LOAD_OBSTACLE = 2'd1,
        OP_QUERY         = 2'd2,
        OP_UNUSED        = 2'd3
    } t_op;

    typedef enum logic {
        REG_VERTEX_COUNT   = 1'b0,
        REG_OBSTACLE_COUNT = 1'b1
    } t_reg;

    // query token travelling down the row of cells
    typedef struct packed {
        t_coord px;
        t_coord py;
        logic   par_h;
        logic   par_v;
        logic   obs;
    } t_token;

endpackage

/* design/rpip_vertex_cell.sv */
`timescale 1ns / 1ps
// one contour cell: holds a vertex and tests the edge to its neighbour's vertex
// depends on rpip_pkg

module rpip_vertex_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr_en,
    input  rpip_pkg::t_coord      i_wr_x,
    input  rpip_pkg::t_coord      i_wr_y,
    input  logic                  i_edge_en,
    input  rpip_pkg::t_coord      i_next_x,
    input  rpip_pkg::t_coord      i_next_y,
    input  logic                  i_adv,
    input  logic                  i_tok_valid,
    input  rpip_pkg::t_token      i_tok,
    output rpip_pkg::t_coord      o_x,
    output rpip_pkg::t_coord      o_y,
    output logic                  o_tok_valid,
    output rpip_pkg::t_token      o_tok
);

    rpip_pkg::t_coord r_x;
    rpip_pkg::t_coord r_y;
    logic             r_tok_valid;
    rpip_pkg::t_token r_tok;
    rpip_pkg::t_token n_tok;
    logic             ystr;
    logic             xstr;
    logic             hit_h;
    logic             hit_v;

    always_comb begin
        ystr  = (r_y < i_tok.py && i_next_y >= i_tok.py)
             || (i_next_y < i_tok.py && r_y >= i_tok.py);
        xstr  = (r_x < i_tok.px && i_next_x >= i_tok.px)
             || (i_next_x < i_tok.px && r_x >= i_tok.px);
        hit_h = i_edge_en && r_x > i_tok.px && i_next_x > i_tok.px && ystr
             && r_y != i_next_y;
        hit_v = i_edge_en && xstr && r_y < i_tok.py && i_next_y < i_tok.py
             && r_x != i_next_x;
        n_tok       = i_tok;
        n_tok.par_h = i_tok.par_h ^ hit_h;
        n_tok.par_v = i_tok.par_v ^ hit_v;
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_x <= i_wr_x;
            r_y <= i_wr_y;
        end
        if (i_adv) begin
            r_tok <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok_valid <= 1'b0;
        end else if (i_adv) begin
            r_tok_valid <= i_tok_valid;
        end
    end

    assign o_x         = r_x;
    assign o_y         = r_y;
    assign o_tok_valid = r_tok_valid;
    assign o_tok       = r_tok;

endmodule

/* design/rpip_obstacle_cell.sv */
`timescale 1ns / 1ps
// one obstacle cell: holds a rectangle and marks tokens whose point falls in it
// depends on rpip_pkg

module rpip_obstacle_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr_en,
    input  rpip_pkg::t_coord      i_wr_x,
    input  rpip_pkg::t_coord      i_wr_y,
    input  rpip_pkg::t_coord      i_wr_w,
    input  rpip_pkg::t_coord      i_wr_h,
    input  logic                  i_box_en,
    input  logic                  i_adv,
    input  logic                  i_tok_valid,
    input  rpip_pkg::t_token      i_tok,
    output logic                  o_tok_valid,
    output rpip_pkg::t_token      o_tok
);

    rpip_pkg::t_coord r_cx;
    rpip_pkg::t_coord r_cy;
    rpip_pkg::t_half  r_hw;
    rpip_pkg::t_half  r_hh;
    logic             r_tok_valid;
    rpip_pkg::t_token r_tok;
    rpip_pkg::t_token n_tok;
    rpip_pkg::t_coord dx;
    rpip_pkg::t_coord dy;
    logic             hit;

    always_comb begin
        dx  = (i_tok.px >= r_cx) ? i_tok.px - r_cx : r_cx - i_tok.px;
        dy  = (i_tok.py >= r_cy) ? i_tok.py - r_cy : r_cy - i_tok.py;
        hit = i_box_en && dx <= {1'b0, r_hw} && dy <= {1'b0, r_hh};
        n_tok     = i_tok;
        n_tok.obs = i_tok.obs | hit;
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_cx <= i_wr_x;
            r_cy <= i_wr_y;
            r_hw <= i_wr_w[rpip_pkg::COORD_BITS-1:1];
            r_hh <= i_wr_h[rpip_pkg::COORD_BITS-1:1];
        end
        if (i_adv) begin
            r_tok <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok_valid <= 1'b0;
        end else if (i_adv) begin
            r_tok_valid <= i_tok_valid;
        end
    end

    assign o_tok_valid = r_tok_valid;
    assign o_tok       = r_tok;

endmodule

/* design/rectilinear_point_in_polygon_unit.sv */
`timescale 1ns / 1ps
// top level: input and register ports, the row of vertex and obstacle cells, result register
// depends on rpip_pkg, rpip_vertex_cell, rpip_obstacle_cell

// A query item travels as a token through a row of MAX_VERTICES contour cells and then
// MAX_OBSTACLES obstacle cells, one cell per cycle while the output does not stall, and
// its result is then written into the output register.
// Only one query is in flight: o_ready is low from query accept until its result is
// registered; load items give no result. The result may wait in the output register
// while the next item is accepted.

module rectilinear_point_in_polygon_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_op,
    input  logic [5:0]  i_slot,
    input  logic [11:0] i_pos_x,
    input  logic [11:0] i_pos_y,
    input  logic [11:0] i_box_width,
    input  logic [11:0] i_box_height,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_inside_res,
    output logic        o_in_obstacle
);

    localparam int NV = rpip_pkg::MAX_VERTICES;
    localparam int NO = rpip_pkg::MAX_OBSTACLES;

    logic [rpip_pkg::VCOUNT_W-1:0] r_vertex_count;
    logic [rpip_pkg::OCOUNT_W-1:0] r_obstacle_count;
    logic                          r_busy;
    logic                          r_out_valid;
    logic                          r_inside;
    logic                          r_obs;

    logic             accept;
    logic             adv;
    logic             cfg_wr;
    rpip_pkg::t_op    op;
    rpip_pkg::t_token entry_tok;

    rpip_pkg::t_coord vx [NV];
    rpip_pkg::t_coord vy [NV];
    logic             v_valid [NV+1];
    rpip_pkg::t_token v_tok   [NV+1];
    logic             o_valid_c [NO+1];
    rpip_pkg::t_token o_tok_c   [NO+1];

    assign op     = rpip_pkg::t_op'(i_op);
    assign o_ready = !r_busy;
    assign accept = i_valid && o_ready;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    // whole row holds while a finished result cannot leave
    assign adv = !(o_valid_c[NO] && r_out_valid && !i_ready);

    always_comb begin
        entry_tok.px    = i_pos_x;
        entry_tok.py    = i_pos_y;
        entry_tok.par_h = 1'b0;
        entry_tok.par_v = 1'b0;
        entry_tok.obs   = 1'b0;
    end

    assign v_valid[0] = accept && op == rpip_pkg::OP_QUERY;
    assign v_tok[0]   = entry_tok;

    for (genvar i = 0; i < NV; i++) begin : g_vcell
        rpip_pkg::t_coord nx;
        rpip_pkg::t_coord ny;
        if (i + 1 < NV) begin : g_mid
            assign nx = vx[i+1];
            assign ny = vy[i+1];
        end else begin : g_last
            assign nx = vx[i];
            assign ny = vy[i];
        end
        rpip_vertex_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_wr_en     (accept && op == rpip_pkg::OP_LOAD_VERTEX
                          && i_slot == rpip_pkg::SLOT_W'(i)),
            .i_wr_x      (i_pos_x),
            .i_wr_y      (i_pos_y),
            .i_edge_en   (rpip_pkg::VCOUNT_W'(i + 1) < r_vertex_count),
            .i_next_x    (nx),
            .i_next_y    (ny),
            .i_adv       (adv),
            .i_tok_valid (v_valid[i]),
            .i_tok       (v_tok[i]),
            .o_x         (vx[i]),
            .o_y         (vy[i]),
            .o_tok_valid (v_valid[i+1]),
            .o_tok       (v_tok[i+1])
        );
    end

    assign o_valid_c[0] = v_valid[NV];
    assign o_tok_c[0]   = v_tok[NV];

    for (genvar k = 0; k < NO; k++) begin : g_ocell
        rpip_obstacle_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_wr_en     (accept && op == rpip_pkg::OP_LOAD_OBSTACLE
                          && i_slot == rpip_pkg::SLOT_W'(k)),
            .i_wr_x      (i_pos_x),
            .i_wr_y      (i_pos_y),
            .i_wr_w      (i_box_width),
            .i_wr_h      (i_box_height),
            .i_box_en    (rpip_pkg::OCOUNT_W'(k) < r_obstacle_count),
            .i_adv       (adv),
            .i_tok_valid (o_valid_c[k]),
            .i_tok       (o_tok_c[k]),
            .o_tok_valid (o_valid_c[k+1]),
            .o_tok       (o_tok_c[k+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count   <= '0;
            r_obstacle_count <= '0;
        end else if (cfg_wr) begin
            unique case (rpip_pkg::t_reg'(paddr[2]))
                rpip_pkg::REG_VERTEX_COUNT: begin
                    r_vertex_count <= pwdata[rpip_pkg::VCOUNT_W-1:0];
                end
                rpip_pkg::REG_OBSTACLE_COUNT: begin
                    r_obstacle_count <= pwdata[rpip_pkg::OCOUNT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (rpip_pkg::t_reg'(paddr[2]))
            rpip_pkg::REG_VERTEX_COUNT: begin
                prdata = 32'(r_vertex_count);
            end
            rpip_pkg::REG_OBSTACLE_COUNT: begin
                prdata = 32'(r_obstacle_count);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (v_valid[0]) begin
                r_busy <= 1'b1;
            end else if (o_valid_c[NO] && adv) begin
                r_busy <= 1'b0;
            end
            if (o_valid_c[NO] && adv) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_valid_c[NO] && adv) begin
            r_obs    <= o_tok_c[NO].obs;
            r_inside <= !o_tok_c[NO].obs && o_tok_c[NO].par_h && o_tok_c[NO].par_v;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_inside_res  = r_inside;
    assign o_in_obstacle = r_obs;

endmodule
